>>> rtl/mpv_pkg.sv
// Package: types, constants and SHA-256 helpers for the Merkle proof verifier.
package mpv_pkg;

	localparam int HashWords = 4;
	localparam logic [7:0] CombineTag = 8'h03;
	localparam int HashBytes = 32;
	localparam logic [63:0] MsgBits = 64'((1 + 2 * HashBytes) * 8);

	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_COMBINE = 2'd1,
		CMD_COMPARE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] hash_word0;
		logic [63:0] hash_word1;
		logic [63:0] hash_word2;
		logic [63:0] hash_word3;
		logic        sibling_on_left;
	} in_req_t;

	typedef struct packed {
		logic        proof_ok;
		logic [63:0] root_word0;
		logic [63:0] root_word1;
		logic [63:0] root_word2;
		logic [63:0] root_word3;
	} out_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_BLK0,
		ST_BLK1,
		ST_STORE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_leaf;
		logic capture;
		logic start_blk0;
		logic round_en;
		logic fold;
		logic store;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last_round;
	} dp_sts_t;

	function automatic logic [31:0] sha_k(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
		};
		return k[i];
	endfunction

	localparam logic [255:0] ShaInit = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

endpackage

>>> rtl/merkle_proof_verifier_top.sv
// Sequence: a leaf load writes the running hash on acceptance; a combine runs set-up (INIT),
// two blocks of 64 rounds (BLK0, BLK1) and a store of the new running hash (STORE); compare
// gives its result the cycle after acceptance and holds it until taken.
// Throughput: one request at a time; a load can follow every cycle, while a combine or
// compare stalls the input until done. The single SHA-256 round unit does all hashing.
// Reset: arst_n clears the controller and the running hash to zero.
module merkle_proof_verifier_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mpv_pkg::in_req_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mpv_pkg::out_req_t  out_data
);
	import mpv_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mpv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_cmd(in_data.cmd),
		.out_stall(out_stall), .sts(sts), .in_stall(in_stall),
		.out_valid(out_valid), .cmd(cmd)
	);

	mpv_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_req(in_data), .cmd(cmd),
		.sts(sts), .out_req(out_data)
	);
endmodule

>>> rtl/mpv_ctrl.sv
// Controller: sequences leaf loads, two-block hashes and root compares.
module mpv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_cmd,
	input  logic              out_stall,
	input  mpv_pkg::dp_sts_t  sts,
	output logic              in_stall,
	output logic              out_valid,
	output mpv_pkg::dp_cmd_t  cmd
);
	import mpv_pkg::*;

	state_t state_q, state_d;
	logic   acc;

	assign acc = in_valid && !in_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && in_cmd == CMD_COMBINE) state_d = ST_INIT;
				else if (acc && in_cmd == CMD_COMPARE) state_d = ST_EMIT;
			end
			ST_INIT: state_d = ST_BLK0;
			ST_BLK0: if (sts.last_round) state_d = ST_BLK1;
			ST_BLK1: if (sts.last_round) state_d = ST_STORE;
			ST_STORE: state_d = ST_IDLE;
			ST_EMIT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		case (state_q)
			ST_IDLE: begin
				cmd.load_leaf = acc && in_cmd == CMD_LOAD;
				cmd.capture = acc;
			end
			ST_INIT: cmd.start_blk0 = 1'b1;
			ST_BLK0: begin
				cmd.round_en = 1'b1;
				cmd.fold = sts.last_round;
			end
			ST_BLK1: begin
				cmd.round_en = 1'b1;
				cmd.fold = sts.last_round;
			end
			ST_STORE: cmd.store = 1'b1;
			ST_EMIT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLK0 || state_q == ST_BLK1) |-> in_stall && !out_valid)
		else $error("input taken while hashing");
	a_emit_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(acc) && $past(in_cmd) == CMD_COMPARE)
		else $error("result without compare request");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");
endmodule

>>> rtl/mpv_dp.sv
// Datapath: running hash, message schedule and one SHA-256 round a cycle.
module mpv_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mpv_pkg::in_req_t  in_req,
	input  mpv_pkg::dp_cmd_t  cmd,
	output mpv_pkg::dp_sts_t  sts,
	output mpv_pkg::out_req_t out_req
);
	import mpv_pkg::*;

	logic [255:0] run_q;
	logic [255:0] given_q;
	logic         sol_q;
	logic [255:0] st_q;   // a..h
	logic [255:0] h_q;    // chaining value
	logic [31:0]  w_q [16];
	logic [5:0]   rnd_q;

	logic [519:0] msg;
	logic [511:0] blk0, blk1;
	logic [255:0] left, right;
	logic [255:0] fold_h;
	logic [31:0]  a, b, c, d, e, f, g, hh, t1, t2, s0, s1, wn;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// build the padded message
	always_comb begin
		left = sol_q ? given_q : run_q;
		right = sol_q ? run_q : given_q;
		msg = {CombineTag, left, right};
		blk0 = msg[519:8];
		blk1 = {msg[7:0], 8'h80, 432'd0, MsgBits};
	end

	// one compression round and schedule step
	always_comb begin
		{a, b, c, d, e, f, g, hh} = st_q;
		t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ sha_k(rnd_q) + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	// add the state after the last round into the chaining value
	assign fold_h = {h_q[255:224] + t1 + t2, h_q[223:192] + a, h_q[191:160] + b,
		h_q[159:128] + c, h_q[127:96] + d + t1, h_q[95:64] + e,
		h_q[63:32] + f, h_q[31:0] + g};

	assign sts.last_round = (rnd_q == 6'd63);

	// hold the running hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) run_q <= '0;
		else if (cmd.load_leaf) run_q <= {in_req.hash_word0, in_req.hash_word1,
			in_req.hash_word2, in_req.hash_word3};
		else if (cmd.store) run_q <= h_q;
	end

	// capture the request and advance the rounds
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			given_q <= {in_req.hash_word0, in_req.hash_word1,
				in_req.hash_word2, in_req.hash_word3};
			sol_q <= in_req.sibling_on_left;
		end
		if (cmd.start_blk0) begin
			h_q <= ShaInit;
			st_q <= ShaInit;
			rnd_q <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= blk0[511 - 32 * i -: 32];
		end else if (cmd.fold) begin
			h_q <= fold_h;
			st_q <= fold_h;
			rnd_q <= '0;
			for (int i = 0; i < 16; i++) w_q[i] <= blk1[511 - 32 * i -: 32];
		end else if (cmd.round_en) begin
			st_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
			rnd_q <= rnd_q + 6'd1;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wn;
		end
	end

	assign out_req.proof_ok = (run_q == given_q);
	assign out_req.root_word0 = run_q[255:192];
	assign out_req.root_word1 = run_q[191:128];
	assign out_req.root_word2 = run_q[127:64];
	assign out_req.root_word3 = run_q[63:0];

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en && !cmd.fold |=> rnd_q == $past(rnd_q) + 6'd1)
		else $error("round counter skipped");
	a_run_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round_en |=> $stable(run_q))
		else $error("running hash changed mid-hash");
	a_fold_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fold |-> sts.last_round)
		else $error("fold before last round");
endmodule
